[sv/dpt_pkg.sv]
`default_nettype none

package dpt_pkg;

    // item field widths
    localparam int BOX_W      = 12;
    localparam int ANGLE_W    = 16;
    localparam int AREA_TGT_W = 24;
    localparam int OUT_W      = 16;

    // loop arithmetic
    localparam int GAIN_W      = 40;
    localparam int INTEG_W     = 48;
    localparam int GAIN_SPLIT  = 20;
    localparam int INTEG_SPLIT = 24;
    localparam int ANGLE_ERR_W = ANGLE_W + 1;
    localparam int AREA_ERR_W  = AREA_TGT_W + 2;
    localparam int ANGLE_SHIFT = 28;
    localparam int AREA_SHIFT  = 20;

    // output shaping defaults
    localparam int AREA_LIMIT_HIGH_DEF  = 3277;
    localparam int AREA_LIMIT_LOW_DEF   = 41;
    localparam int ANGLE_LIMIT_HIGH_DEF = 3277;
    localparam int ANGLE_LIMIT_LOW_DEF  = 41;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_ANGLE     = 3'd0,
        CFG_KI_ANGLE     = 3'd1,
        CFG_KD_ANGLE     = 3'd2,
        CFG_KP_AREA      = 3'd3,
        CFG_KI_AREA      = 3'd4,
        CFG_KD_AREA      = 3'd5,
        CFG_TARGET_AREA  = 3'd6,
        CFG_TARGET_ANGLE = 3'd7
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0]     KP_ANGLE_RST     = 40'd42949673;
    localparam logic [GAIN_W-1:0]     KI_ANGLE_RST     = 40'd0;
    localparam logic [GAIN_W-1:0]     KD_ANGLE_RST     = 40'd0;
    localparam logic [GAIN_W-1:0]     KP_AREA_RST      = 40'd17180;
    localparam logic [GAIN_W-1:0]     KI_AREA_RST      = 40'd0;
    localparam logic [GAIN_W-1:0]     KD_AREA_RST      = 40'd0;
    localparam logic [AREA_TGT_W-1:0] TARGET_AREA_RST  = 24'd75000;
    localparam logic [ANGLE_W-1:0]    TARGET_ANGLE_RST = 16'd0;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } dpt_ld_t;

endpackage

`default_nettype wire

[sv/dpt_det_if.sv]
`default_nettype none

interface dpt_det_if import dpt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      is_target;
    logic        [BOX_W-1:0]   box_width;
    logic        [BOX_W-1:0]   box_height;
    logic signed [ANGLE_W-1:0] bearing;

    modport source (output valid, output is_target, output box_width,
                    output box_height, output bearing, input ready);
    modport sink   (input valid, input is_target, input box_width,
                    input box_height, input bearing, output ready);
endinterface

`default_nettype wire

[sv/dpt_cmd_if.sv]
`default_nettype none

interface dpt_cmd_if import dpt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] forward_speed;
    logic signed [OUT_W-1:0] turn_rate;

    modport source (output valid, output forward_speed, output turn_rate, input ready);
    modport sink   (input valid, input forward_speed, input turn_rate, output ready);
endinterface

`default_nettype wire

[sv/dpt_front.sv]
`default_nettype none

module dpt_front import dpt_pkg::*; (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dpt_ld_t                       ld,
    input  wire logic        [BOX_W-1:0]       box_width,
    input  wire logic        [BOX_W-1:0]       box_height,
    input  wire logic signed [ANGLE_W-1:0]     bearing,
    input  wire logic        [AREA_TGT_W-1:0]  target_area,
    input  wire logic signed [ANGLE_W-1:0]     target_angle,
    output logic signed      [ANGLE_ERR_W-1:0] angle_err,
    output logic signed      [INTEG_W-1:0]     angle_integ,
    output logic signed      [ANGLE_ERR_W:0]   angle_diff,
    output logic signed      [AREA_ERR_W-1:0]  area_err,
    output logic signed      [INTEG_W-1:0]     area_integ,
    output logic signed      [AREA_ERR_W:0]    area_diff
);

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    logic        [2*BOX_W-1:0]     area;
    logic signed [ANGLE_ERR_W-1:0] ea_next, ea_reg;
    logic signed [AREA_ERR_W-1:0]  eb_next, eb_reg;

    logic signed [ANGLE_ERR_W-1:0] angle_prev_reg;
    logic signed [AREA_ERR_W-1:0]  area_prev_reg;
    logic signed [INTEG_W-1:0]     angle_integ_reg, angle_integ_next;
    logic signed [INTEG_W-1:0]     area_integ_reg, area_integ_next;
    logic signed [ANGLE_ERR_W:0]   angle_diff_reg, angle_diff_next;
    logic signed [AREA_ERR_W:0]    area_diff_reg, area_diff_next;
    logic signed [INTEG_W:0]       angle_sum, area_sum;

    // stage 1: errors
    always_comb
    begin
        area    = {{BOX_W{1'b0}}, box_width} * {{BOX_W{1'b0}}, box_height};
        ea_next = ANGLE_ERR_W'(target_angle) - ANGLE_ERR_W'(bearing);
        eb_next = $signed({2'b00, target_area}) - $signed({2'b00, area});
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            ea_reg <= ea_next;
            eb_reg <= eb_next;
        end
    end

    // stage 2: integrators with saturation, difference to previous error
    always_comb
    begin
        angle_sum = (INTEG_W+1)'(angle_integ_reg) + (INTEG_W+1)'(ea_reg);
        area_sum  = (INTEG_W+1)'(area_integ_reg) + (INTEG_W+1)'(eb_reg);

        if (angle_sum[INTEG_W] != angle_sum[INTEG_W-1])
            angle_integ_next = angle_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
            angle_integ_next = angle_sum[INTEG_W-1:0];

        if (area_sum[INTEG_W] != area_sum[INTEG_W-1])
            area_integ_next = area_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
            area_integ_next = area_sum[INTEG_W-1:0];

        angle_diff_next = (ANGLE_ERR_W+1)'(ea_reg) - (ANGLE_ERR_W+1)'(angle_prev_reg);
        area_diff_next  = (AREA_ERR_W+1)'(eb_reg) - (AREA_ERR_W+1)'(area_prev_reg);
    end

    // loop state doubles as the stage 2 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_integ_reg <= '0;
            area_integ_reg  <= '0;
            angle_prev_reg  <= '0;
            area_prev_reg   <= '0;
        end
        else if (ld.s2)
        begin
            angle_integ_reg <= angle_integ_next;
            area_integ_reg  <= area_integ_next;
            angle_prev_reg  <= ea_reg;
            area_prev_reg   <= eb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s2)
        begin
            angle_diff_reg <= angle_diff_next;
            area_diff_reg  <= area_diff_next;
        end
    end

    assign angle_err   = angle_prev_reg;
    assign angle_integ = angle_integ_reg;
    assign angle_diff  = angle_diff_reg;
    assign area_err    = area_prev_reg;
    assign area_integ  = area_integ_reg;
    assign area_diff   = area_diff_reg;

endmodule

`default_nettype wire

[sv/dpt_loop.sv]
`default_nettype none

module dpt_loop import dpt_pkg::*; #(
    parameter int ERR_W      = ANGLE_ERR_W,
    parameter int SHIFT      = ANGLE_SHIFT,
    parameter int LIMIT_LOW  = ANGLE_LIMIT_LOW_DEF,
    parameter int LIMIT_HIGH = ANGLE_LIMIT_HIGH_DEF
) (
    input  wire logic                     clk,
    input  wire dpt_ld_t                  ld,
    input  wire logic signed [GAIN_W-1:0] kp,
    input  wire logic signed [GAIN_W-1:0] ki,
    input  wire logic signed [GAIN_W-1:0] kd,
    input  wire logic signed [ERR_W-1:0]  err,
    input  wire logic signed [INTEG_W-1:0] integ,
    input  wire logic signed [ERR_W:0]    diff,
    output logic signed      [OUT_W-1:0]  value
);

    localparam int KH_W  = GAIN_W - GAIN_SPLIT;
    localparam int KL_W  = GAIN_SPLIT + 1;
    localparam int IH_W  = INTEG_W - INTEG_SPLIT;
    localparam int IL_W  = INTEG_SPLIT + 1;
    localparam int DF_W  = ERR_W + 1;
    localparam int SUM_W = GAIN_W + INTEG_W + 2;

    localparam logic signed [SUM_W-1:0] LO_P = SUM_W'(LIMIT_LOW);
    localparam logic signed [SUM_W-1:0] LO_N = -LO_P;
    localparam logic signed [SUM_W-1:0] HI_P = SUM_W'(LIMIT_HIGH);
    localparam logic signed [SUM_W-1:0] HI_N = -HI_P;

    logic signed [KH_W-1:0] kp_h, ki_h, kd_h;
    logic signed [KL_W-1:0] kp_l, ki_l, kd_l;
    logic signed [IH_W-1:0] in_h;
    logic signed [IL_W-1:0] in_l;

    // stage 3: partial products, none wider than 21 x 27
    logic signed [KH_W+ERR_W-1:0] pp_eh_reg;
    logic signed [KL_W+ERR_W-1:0] pp_el_reg;
    logic signed [KH_W+DF_W-1:0]  pp_dh_reg;
    logic signed [KL_W+DF_W-1:0]  pp_dl_reg;
    logic signed [KH_W+IH_W-1:0]  pp_hh_reg;
    logic signed [KH_W+IL_W-1:0]  pp_hl_reg;
    logic signed [KL_W+IH_W-1:0]  pp_lh_reg;
    logic signed [KL_W+IL_W-1:0]  pp_ll_reg;

    // stage 4, 5 and 6
    logic signed [SUM_W-1:0] p_kp_reg, p_ki_reg, p_kd_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sh;
    logic signed [OUT_W-1:0] value_reg, value_next;

    always_comb
    begin
        kp_h = $signed(kp[GAIN_W-1:GAIN_SPLIT]);
        ki_h = $signed(ki[GAIN_W-1:GAIN_SPLIT]);
        kd_h = $signed(kd[GAIN_W-1:GAIN_SPLIT]);
        kp_l = $signed({1'b0, kp[GAIN_SPLIT-1:0]});
        ki_l = $signed({1'b0, ki[GAIN_SPLIT-1:0]});
        kd_l = $signed({1'b0, kd[GAIN_SPLIT-1:0]});
        in_h = $signed(integ[INTEG_W-1:INTEG_SPLIT]);
        in_l = $signed({1'b0, integ[INTEG_SPLIT-1:0]});
    end

    always_ff @(posedge clk)
    begin
        if (ld.s3)
        begin
            pp_eh_reg <= kp_h * err;
            pp_el_reg <= kp_l * err;
            pp_dh_reg <= kd_h * diff;
            pp_dl_reg <= kd_l * diff;
            pp_hh_reg <= ki_h * in_h;
            pp_hl_reg <= ki_h * in_l;
            pp_lh_reg <= ki_l * in_h;
            pp_ll_reg <= ki_l * in_l;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s4)
        begin
            p_kp_reg <= (SUM_W'(pp_eh_reg) <<< GAIN_SPLIT) + SUM_W'(pp_el_reg);
            p_kd_reg <= (SUM_W'(pp_dh_reg) <<< GAIN_SPLIT) + SUM_W'(pp_dl_reg);
            p_ki_reg <= (SUM_W'(pp_hh_reg) <<< (GAIN_SPLIT + INTEG_SPLIT))
                      + (SUM_W'(pp_hl_reg) <<< GAIN_SPLIT)
                      + (SUM_W'(pp_lh_reg) <<< INTEG_SPLIT)
                      + SUM_W'(pp_ll_reg);
        end
        if (ld.s5)
            sum_reg <= p_kp_reg + p_ki_reg + p_kd_reg;
        if (ld.s6)
            value_reg <= value_next;
    end

    // floor shift to Q4.12, then deadband and limiter on the full-width value
    always_comb
    begin
        sh = sum_reg >>> SHIFT;
        if (sh <= LO_P && sh >= LO_N)
            value_next = '0;
        else if (sh < HI_P && sh > HI_N)
            value_next = sh[OUT_W-1:0];
        else if (sh[SUM_W-1])
            value_next = HI_N[OUT_W-1:0];
        else
            value_next = HI_P[OUT_W-1:0];
    end

    assign value = value_reg;

endmodule

`default_nettype wire

[sv/dual_pid_tracking_controller.sv]
// Channel | Dir | Payload                                   | Handshake
// det     | in  | is_target, box_width, box_height, bearing | valid/ready
// cmd     | out | forward_speed, turn_rate                  | valid/ready
// cfg_wr  | in  | cfg_wr_idx, cfg_wr_data                   | cfg_wr_en only
//
// One item per cycle sustained while cmd is ready; a target item shows on cmd
// once it reaches the output register. Non-target items are taken and dropped without a result.
// Six pipeline stages: errors, integrators, partial products, products,
// loop sum, shaping into the output register.
// Reset loads the default gains and targets and clears integrators and
// previous errors. A stalled cmd lets earlier stages close their bubbles;
// det.ready falls only when stage one is full and cannot move.
`default_nettype none

module dual_pid_tracking_controller import dpt_pkg::*; #(
    parameter int AREA_LIMIT_HIGH  = AREA_LIMIT_HIGH_DEF,
    parameter int AREA_LIMIT_LOW   = AREA_LIMIT_LOW_DEF,
    parameter int ANGLE_LIMIT_HIGH = ANGLE_LIMIT_HIGH_DEF,
    parameter int ANGLE_LIMIT_LOW  = ANGLE_LIMIT_LOW_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dpt_det_if.sink                    det,
    dpt_cmd_if.source                  cmd,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int NSTG = 6;

    logic [GAIN_W-1:0]     kp_angle_reg, ki_angle_reg, kd_angle_reg;
    logic [GAIN_W-1:0]     kp_area_reg, ki_area_reg, kd_area_reg;
    logic [AREA_TGT_W-1:0] target_area_reg;
    logic [ANGLE_W-1:0]    target_angle_reg;

    logic [NSTG-1:0] v_reg, v_next, rdy;
    dpt_ld_t         ld;

    logic signed [ANGLE_ERR_W-1:0] angle_err;
    logic signed [INTEG_W-1:0]     angle_integ;
    logic signed [ANGLE_ERR_W:0]   angle_diff;
    logic signed [AREA_ERR_W-1:0]  area_err;
    logic signed [INTEG_W-1:0]     area_integ;
    logic signed [AREA_ERR_W:0]    area_diff;
    logic signed [OUT_W-1:0]       turn_value, speed_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_angle_reg     <= KP_ANGLE_RST;
            ki_angle_reg     <= KI_ANGLE_RST;
            kd_angle_reg     <= KD_ANGLE_RST;
            kp_area_reg      <= KP_AREA_RST;
            ki_area_reg      <= KI_AREA_RST;
            kd_area_reg      <= KD_AREA_RST;
            target_area_reg  <= TARGET_AREA_RST;
            target_angle_reg <= TARGET_ANGLE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_wr_idx))
                CFG_KP_ANGLE:     kp_angle_reg     <= cfg_wr_data;
                CFG_KI_ANGLE:     ki_angle_reg     <= cfg_wr_data;
                CFG_KD_ANGLE:     kd_angle_reg     <= cfg_wr_data;
                CFG_KP_AREA:      kp_area_reg      <= cfg_wr_data;
                CFG_KI_AREA:      ki_area_reg      <= cfg_wr_data;
                CFG_KD_AREA:      kd_area_reg      <= cfg_wr_data;
                CFG_TARGET_AREA:  target_area_reg  <= cfg_wr_data[AREA_TGT_W-1:0];
                CFG_TARGET_ANGLE: target_angle_reg <= cfg_wr_data[ANGLE_W-1:0];
                default:          ;
            endcase
        end
    end

    // a stage can take new data if it is empty or its item moves on
    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || cmd.ready;
        for (int k = NSTG - 2; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];

        v_next[0] = rdy[0] ? (det.valid && det.is_target) : v_reg[0];
        for (int k = 1; k < NSTG; k++)
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];

        ld.s1 = rdy[0] && det.valid && det.is_target;
        ld.s2 = rdy[1] && v_reg[0];
        ld.s3 = rdy[2] && v_reg[1];
        ld.s4 = rdy[3] && v_reg[2];
        ld.s5 = rdy[4] && v_reg[3];
        ld.s6 = rdy[5] && v_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    dpt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .ld           (ld),
        .box_width    (det.box_width),
        .box_height   (det.box_height),
        .bearing      (det.bearing),
        .target_area  (target_area_reg),
        .target_angle ($signed(target_angle_reg)),
        .angle_err    (angle_err),
        .angle_integ  (angle_integ),
        .angle_diff   (angle_diff),
        .area_err     (area_err),
        .area_integ   (area_integ),
        .area_diff    (area_diff)
    );

    dpt_loop #(
        .ERR_W      (ANGLE_ERR_W),
        .SHIFT      (ANGLE_SHIFT),
        .LIMIT_LOW  (ANGLE_LIMIT_LOW),
        .LIMIT_HIGH (ANGLE_LIMIT_HIGH)
    ) u_angle_loop (
        .clk   (clk),
        .ld    (ld),
        .kp    ($signed(kp_angle_reg)),
        .ki    ($signed(ki_angle_reg)),
        .kd    ($signed(kd_angle_reg)),
        .err   (angle_err),
        .integ (angle_integ),
        .diff  (angle_diff),
        .value (turn_value)
    );

    dpt_loop #(
        .ERR_W      (AREA_ERR_W),
        .SHIFT      (AREA_SHIFT),
        .LIMIT_LOW  (AREA_LIMIT_LOW),
        .LIMIT_HIGH (AREA_LIMIT_HIGH)
    ) u_area_loop (
        .clk   (clk),
        .ld    (ld),
        .kp    ($signed(kp_area_reg)),
        .ki    ($signed(ki_area_reg)),
        .kd    ($signed(kd_area_reg)),
        .err   (area_err),
        .integ (area_integ),
        .diff  (area_diff),
        .value (speed_value)
    );

    assign det.ready         = rdy[0];
    assign cmd.valid         = v_reg[NSTG-1];
    assign cmd.turn_rate     = turn_value;
    assign cmd.forward_speed = speed_value;

`ifndef SYNTHESIS
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> det.ready)
        else $error("det.ready low with stage one empty");

    a_drop_nontarget: assert property (@(posedge clk) disable iff (!rst_n)
        det.valid && det.ready && !det.is_target |=> !v_reg[0])
        else $error("non-target item entered the pipeline");

    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTG-2] && !cmd.valid |=> cmd.valid)
        else $error("item did not reach the output register");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !cmd.ready |-> !det.ready)
        else $error("input taken while pipeline full and stalled");
`endif

endmodule

`default_nettype wire
